### rtl/bbc_pkg.sv
package bbc_pkg;

  // Frame geometry limits
  localparam int MAX_WIDTH     = 1024;
  localparam int MAX_HEIGHT    = 1024;
  localparam int MAX_DIVISOR   = 1024;
  localparam int FRACTION_BITS = 4;

  // Fixed field widths
  localparam int PIX_W  = 8;
  localparam int SIZE_W = 11;
  localparam int THR_W  = 10;
  localparam int CEN_W  = 14;
  localparam int IDX_W  = 2;

  // Derived widths
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int CNT_W  = COL_W + ROW_W + 1;
  localparam int SUM_W  = COL_W + ROW_W + ((COL_W > ROW_W) ? COL_W : ROW_W);
  localparam int DVD_W  = SUM_W + FRACTION_BITS;
  localparam int DCNT_W = $clog2(DVD_W + 1);
  localparam int AREA_W = 2 * SIZE_W;

  // Result queue
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  // Reset values of the configuration registers
  localparam logic [SIZE_W-1:0] RST_FRAME_WIDTH  = SIZE_W'(320);
  localparam logic [SIZE_W-1:0] RST_FRAME_HEIGHT = SIZE_W'(240);
  localparam logic [THR_W-1:0]  RST_THRESHOLD    = THR_W'(30);
  localparam logic [SIZE_W-1:0] RST_DIVISOR      = SIZE_W'(20);

  typedef enum logic [IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_THRESHOLD    = 2'd2,
    REG_DIVISOR      = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [SIZE_W-1:0]       frame_width;
    logic [SIZE_W-1:0]       frame_height;
    logic signed [THR_W-1:0] color_threshold;
    logic [SIZE_W-1:0]       area_divisor;
  } cfg_t;

  // One queued pixel, with frame totals riding along on the last pixel
  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             frame_end;
    logic [SUM_W-1:0] sum_x;
    logic [SUM_W-1:0] sum_y;
    logic [CNT_W-1:0] count;
  } item_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic [FCNT_W-1:0] count;
  } fifo_stat_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  // Saturate a size register into [1, hi]
  function automatic logic [SIZE_W-1:0] size_clamp(logic [SIZE_W-1:0] v,
                                                   logic [SIZE_W-1:0] hi);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

### rtl/bbc_front.sv
module bbc_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bbc_pkg::cfg_t             cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [bbc_pkg::PIX_W-1:0] in_red,
  input  logic [bbc_pkg::PIX_W-1:0] in_green,
  input  logic [bbc_pkg::PIX_W-1:0] in_blue,
  input  bbc_pkg::fifo_stat_t       fifo_st,
  output logic                      push,
  output bbc_pkg::item_t            item
);
  import bbc_pkg::*;

  logic [COL_W-1:0]         col_r, col_nxt;
  logic [ROW_W-1:0]         row_r, row_nxt;
  logic [SUM_W-1:0]         sum_x_r, sum_x_nxt;
  logic [SUM_W-1:0]         sum_y_r, sum_y_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [SIZE_W-1:0]        w_cl, h_cl, w_m1, h_m1;
  logic signed [THR_W:0]    diff, thr;
  logic                     sel, row_end, frame_end;
  logic [SUM_W-1:0]         sx, sy;
  logic [CNT_W-1:0]         sc;

  assign in_ready = !fifo_st.full;
  assign push     = in_valid && in_ready;

  always_comb begin
    w_cl = size_clamp(cfg.frame_width, SIZE_W'(MAX_WIDTH));
    h_cl = size_clamp(cfg.frame_height, SIZE_W'(MAX_HEIGHT));
    w_m1 = w_cl - SIZE_W'(1);
    h_m1 = h_cl - SIZE_W'(1);

    diff = $signed({3'b000, in_blue}) - $signed({3'b000, in_red})
         - $signed({3'b000, in_green});
    thr  = $signed({cfg.color_threshold[THR_W-1], cfg.color_threshold});
    sel  = diff > thr;

    row_end   = col_r >= w_m1[COL_W-1:0];
    frame_end = row_end && (row_r >= h_m1[ROW_W-1:0]);

    // totals include the current pixel
    sx = sum_x_r + (sel ? SUM_W'(col_r) : '0);
    sy = sum_y_r + (sel ? SUM_W'(row_r) : '0);
    sc = cnt_r + CNT_W'(sel);

    item.red       = sel ? in_red   : '0;
    item.green     = sel ? in_green : '0;
    item.blue      = sel ? in_blue  : '0;
    item.frame_end = frame_end;
    item.sum_x     = sx;
    item.sum_y     = sy;
    item.count     = sc;

    col_nxt   = col_r;
    row_nxt   = row_r;
    sum_x_nxt = sum_x_r;
    sum_y_nxt = sum_y_r;
    cnt_nxt   = cnt_r;
    if (push) begin
      priority if (frame_end) begin
        col_nxt   = '0;
        row_nxt   = '0;
        sum_x_nxt = '0;
        sum_y_nxt = '0;
        cnt_nxt   = '0;
      end else if (row_end) begin
        col_nxt   = '0;
        row_nxt   = row_r + ROW_W'(1);
        sum_x_nxt = sx;
        sum_y_nxt = sy;
        cnt_nxt   = sc;
      end else begin
        col_nxt   = col_r + COL_W'(1);
        sum_x_nxt = sx;
        sum_y_nxt = sy;
        cnt_nxt   = sc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      sum_x_r <= '0;
      sum_y_r <= '0;
      cnt_r   <= '0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      sum_x_r <= sum_x_nxt;
      sum_y_r <= sum_y_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

### rtl/bbc_fifo.sv
module bbc_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  bbc_pkg::item_t      wr_item,
  input  logic                pop,
  output bbc_pkg::item_t      rd_item,
  output bbc_pkg::fifo_stat_t stat
);
  import bbc_pkg::*;

  item_t             mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [FCNT_W-1:0] cnt_r, cnt_nxt;

  assign rd_item    = mem_r[rd_ptr_r];
  assign stat.count = cnt_r;
  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == FCNT_W'(FIFO_DEPTH));

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + FCNT_W'(push) - FCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

### rtl/bbc_div.sv
module bbc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  bbc_pkg::div_req_t req,
  output bbc_pkg::div_rsp_t rsp
);
  import bbc_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0]  qd_r, qd_nxt;
  logic [CNT_W:0]    rem_r, rem_nxt, rem_sh;
  logic [CNT_W-1:0]  dsr_r;
  logic              ge;

  assign rsp.done     = done_r;
  assign rsp.quotient = qd_r;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh   = {rem_r[CNT_W-1:0], qd_r[DVD_W-1]};
    ge       = rem_sh >= {1'b0, dsr_r};
    rem_nxt  = ge ? rem_sh - {1'b0, dsr_r} : rem_sh;
    qd_nxt   = {qd_r[DVD_W-2:0], ge};
    done_nxt = busy_r && (cnt_r == DCNT_W'(1));
    busy_nxt = busy_r && !done_nxt;
    cnt_nxt  = busy_r ? cnt_r - DCNT_W'(1) : cnt_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DCNT_W'(DVD_W);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      qd_r  <= req.dividend;
      rem_r <= '0;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      qd_r  <= qd_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

### rtl/bbc_back.sv
module bbc_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bbc_pkg::cfg_t             cfg,
  input  bbc_pkg::item_t            head,
  input  bbc_pkg::fifo_stat_t       fifo_st,
  output logic                      pop,
  output bbc_pkg::div_req_t         div_req,
  input  bbc_pkg::div_rsp_t         div_rsp,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [bbc_pkg::PIX_W-1:0] out_red,
  output logic [bbc_pkg::PIX_W-1:0] out_green,
  output logic [bbc_pkg::PIX_W-1:0] out_blue,
  output logic                      out_frame_end,
  output logic [bbc_pkg::CEN_W-1:0] out_centroid_x,
  output logic [bbc_pkg::CEN_W-1:0] out_centroid_y,
  output logic                      out_object_found
);
  import bbc_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_DIV_X = 7'b0000010,
    ST_DIV_Y = 7'b0000100,
    ST_DIV_W = 7'b0001000,
    ST_DIV_H = 7'b0010000,
    ST_MUL   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  logic              ov_r, ov_nxt;
  logic [PIX_W-1:0]  red_r, green_r, blue_r;
  logic              fe_r, found_r;
  logic [CEN_W-1:0]  ocx_r, ocy_r;
  logic [CEN_W-1:0]  cx_r, cy_r;
  logic [SIZE_W-1:0] wq_r, hq_r;
  logic [AREA_W-1:0] area_r;
  logic              load_ok, load_pix, load_frm, zero_cnt;
  logic [SIZE_W-1:0] w_cl, h_cl, d_cl;
  logic [CEN_W-1:0]  q_cen;

  assign out_valid        = ov_r;
  assign out_red          = red_r;
  assign out_green        = green_r;
  assign out_blue         = blue_r;
  assign out_frame_end    = fe_r;
  assign out_centroid_x   = ocx_r;
  assign out_centroid_y   = ocy_r;
  assign out_object_found = found_r;

  always_comb begin
    w_cl     = size_clamp(cfg.frame_width, SIZE_W'(MAX_WIDTH));
    h_cl     = size_clamp(cfg.frame_height, SIZE_W'(MAX_HEIGHT));
    d_cl     = size_clamp(cfg.area_divisor, SIZE_W'(MAX_DIVISOR));
    zero_cnt = (head.count == '0);
    q_cen    = zero_cnt ? '0 : div_rsp.quotient[CEN_W-1:0];
    load_ok  = !ov_r || out_ready;
    load_pix = 1'b0;
    load_frm = 1'b0;
    state_nxt        = state_r;
    div_req.start    = 1'b0;
    div_req.dividend = DVD_W'(head.sum_x) << FRACTION_BITS;
    div_req.divisor  = head.count;

    unique case (state_r)
      ST_IDLE: begin
        if (!fifo_st.empty) begin
          if (!head.frame_end) begin
            load_pix = load_ok;
          end else begin
            div_req.start = 1'b1;
            state_nxt     = ST_DIV_X;
          end
        end
      end
      ST_DIV_X: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = DVD_W'(head.sum_y) << FRACTION_BITS;
          state_nxt        = ST_DIV_Y;
        end
      end
      ST_DIV_Y: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = DVD_W'(w_cl);
          div_req.divisor  = CNT_W'(d_cl);
          state_nxt        = ST_DIV_W;
        end
      end
      ST_DIV_W: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = DVD_W'(h_cl);
          div_req.divisor  = CNT_W'(d_cl);
          state_nxt        = ST_DIV_H;
        end
      end
      ST_DIV_H: begin
        if (div_rsp.done) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (load_ok) begin
          load_frm  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    pop    = load_pix || load_frm;
    ov_nxt = pop ? 1'b1 : (ov_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // frame-end datapath
  always_ff @(posedge clk) begin
    if (state_r == ST_DIV_X && div_rsp.done) begin
      cx_r <= q_cen;
    end
    if (state_r == ST_DIV_Y && div_rsp.done) begin
      cy_r <= q_cen;
    end
    if (state_r == ST_DIV_W && div_rsp.done) begin
      wq_r <= div_rsp.quotient[SIZE_W-1:0];
    end
    if (state_r == ST_DIV_H && div_rsp.done) begin
      hq_r <= div_rsp.quotient[SIZE_W-1:0];
    end
    if (state_r == ST_MUL) begin
      area_r <= AREA_W'(wq_r) * AREA_W'(hq_r);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (pop) begin
      red_r   <= head.red;
      green_r <= head.green;
      blue_r  <= head.blue;
      fe_r    <= load_frm;
      ocx_r   <= load_frm ? cx_r : '0;
      ocy_r   <= load_frm ? cy_r : '0;
      found_r <= load_frm && (AREA_W'(head.count) > area_r);
    end
  end

endmodule

### rtl/blue_blob_centroid_unit.sv
// Blue blob centroid unit.
// Input channel (in_valid/in_ready): one RGB pixel per transaction, raster
// order; column and row are counted inside, so no coordinates are supplied.
// Output channel (out_valid/out_ready): one transaction per pixel, the pixel
// itself if blue - red - green exceeds the threshold, otherwise black. On the
// frame's last pixel out_frame_end is set and the centroid (4 fraction bits,
// truncated) and the object-found flag are valid; elsewhere they read zero.
// Config channel (cfg_valid/cfg_ready, always ready): cfg_index selects
// width, height, threshold or area divisor; write only while idle.
// An ordinary pixel passes through the queue entry and the output register;
// one pixel per cycle sustained unless the output stalls or a frame end is
// being processed. The frame's last pixel runs four passes through one
// shared bit-serial divider (x, y, width/divisor, height/divisor), then a
// multiply and the output load. A 4-entry queue lets pixels of the next
// frame keep arriving meanwhile until it fills.
// Reset (rst_n low, synchronous) restores the default configuration, clears
// counters, sums and the queue. A stalled receiver holds the output register;
// the queue then fills and in_ready drops.
module blue_blob_centroid_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [bbc_pkg::IDX_W-1:0] cfg_index,
  input  logic [bbc_pkg::SIZE_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [bbc_pkg::PIX_W-1:0] in_red,
  input  logic [bbc_pkg::PIX_W-1:0] in_green,
  input  logic [bbc_pkg::PIX_W-1:0] in_blue,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [bbc_pkg::PIX_W-1:0] out_red,
  output logic [bbc_pkg::PIX_W-1:0] out_green,
  output logic [bbc_pkg::PIX_W-1:0] out_blue,
  output logic                      out_frame_end,
  output logic [bbc_pkg::CEN_W-1:0] out_centroid_x,
  output logic [bbc_pkg::CEN_W-1:0] out_centroid_y,
  output logic                      out_object_found
);
  import bbc_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  fifo_stat_t fifo_st;
  item_t      wr_item, head;
  logic       push, pop;
  div_req_t   div_req;
  div_rsp_t   div_rsp;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  cfg_nxt.frame_width     = cfg_data;
        REG_FRAME_HEIGHT: cfg_nxt.frame_height    = cfg_data;
        REG_THRESHOLD:    cfg_nxt.color_threshold = $signed(cfg_data[THR_W-1:0]);
        REG_DIVISOR:      cfg_nxt.area_divisor    = cfg_data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width     <= RST_FRAME_WIDTH;
      cfg_r.frame_height    <= RST_FRAME_HEIGHT;
      cfg_r.color_threshold <= $signed(RST_THRESHOLD);
      cfg_r.area_divisor    <= RST_DIVISOR;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: classify, count coordinates, accumulate
  bbc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_red   (in_red),
    .in_green (in_green),
    .in_blue  (in_blue),
    .fifo_st  (fifo_st),
    .push     (push),
    .item     (wr_item)
  );

  bbc_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_item (wr_item),
    .pop     (pop),
    .rd_item (head),
    .stat    (fifo_st)
  );

  bbc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // back: frame-end arithmetic and output register
  bbc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .head             (head),
    .fifo_st          (fifo_st),
    .pop              (pop),
    .div_req          (div_req),
    .div_rsp          (div_rsp),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_frame_end    (out_frame_end),
    .out_centroid_x   (out_centroid_x),
    .out_centroid_y   (out_centroid_y),
    .out_object_found (out_object_found)
  );

  // centroid and found flag only on the frame's last pixel
  a_frame_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_end |->
      out_centroid_x == '0 && out_centroid_y == '0 && !out_object_found)
    else $error("frame fields set on an ordinary pixel");

  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_st.count <= FCNT_W'(FIFO_DEPTH))
    else $error("queue occupancy above depth");

  a_fifo_count: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> fifo_st.count == $past(fifo_st.count) + FCNT_W'(1))
    else $error("queue count did not follow a push");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !fifo_st.empty)
    else $error("pop from empty queue");

endmodule
